// ===== rtl/wnpip_pkg.sv =====
// Package for the winding-number point-in-polygon block.
// Default sizes, field widths, mode codes, sequencer states and the read tag.
// No dependencies.
package wnpip_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 32;

    localparam int FIELD_W    = 32;
    localparam int ID_W       = 32;
    localparam int WIND_OUT_W = 11;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_WRAP,
        ST_DRAIN,
        ST_DONE
    } wnpip_state_t;

    // tag that travels with each vertex read
    typedef struct packed {
        logic valid;
        logic first;
        logic wrap;
    } rd_tag_t;

endpackage

// ===== rtl/wnpip_if.sv =====
// Handshake channels of the winding-number block: input word and result word.
// Depends on wnpip_pkg.
interface wnpip_item_if;
    import wnpip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic                      new_polygon;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic [ID_W-1:0]           point_id;

    modport source (output valid, mode, new_polygon, coord_x, coord_y, point_id,
                    input ready);
    modport sink   (input valid, mode, new_polygon, coord_x, coord_y, point_id,
                    output ready);
endinterface

interface wnpip_res_if;
    import wnpip_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ID_W-1:0]              result_id;
    logic signed [WIND_OUT_W-1:0] winding;
    logic                         inside_res;
    logic                         vertices_dropped;

    modport source (output valid, result_id, winding, inside_res, vertices_dropped,
                    input ready);
    modport sink   (input valid, result_id, winding, inside_res, vertices_dropped,
                    output ready);
endinterface

// ===== rtl/winding_number_point_in_polygon.sv =====
// Winding-number point-in-polygon tester, top level.
// Channel items (mode 0) loads one vertex; mode 1 queries one point. A query
// returns one word on results: point id, winding number, inside flag, and
// whether the current polygon lost vertices beyond MAX_VERTICES.
// A load produces no result word.
// A query with n stored vertices walks the vertex store one read per cycle
// (n reads plus the closing edge), then a three-stage subtract, multiply,
// compare pipeline; the result word is then registered.
// The block takes no new word until a query has finished; an empty polygon
// skips the walk and goes straight to registering its answer.
// items.ready is high only while the sequencer is idle.
// The result sits in an output register until taken; the block goes on
// accepting words meanwhile, and a following query holds in its final
// state until that register frees up.
// Reset clears the vertex count, overflow flag, sequencer and output valid;
// store contents are not cleared and only entries below the vertex count are used.
// Depends on wnpip_pkg, wnpip_if, wnpip_vstore, wnpip_edge.
module winding_number_point_in_polygon #(
    parameter int MAX_VERTICES = wnpip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = wnpip_pkg::COORD_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    wnpip_item_if.sink      items,
    wnpip_res_if.source     results
);
    import wnpip_pkg::*;

    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int WIND_W = CNT_W + 1;
    localparam int SAT_W  = (WIND_W > WIND_OUT_W) ? WIND_W : WIND_OUT_W;
    localparam logic signed [SAT_W-1:0] W_MAX = SAT_W'((1 << (WIND_OUT_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] W_MIN = SAT_W'(-(1 << (WIND_OUT_W - 1)));
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    wnpip_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next, base_count;
    logic             ovf_reg, ovf_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    last_idx;

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic [ID_W-1:0]              id_reg;

    logic accept, is_load, is_query, wr_en, out_free, load_out;
    logic items_ready, clear;
    rd_tag_t tag;

    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic signed [WIND_W-1:0]     acc;
    logic                         done;
    logic signed [SAT_W-1:0]      acc_ext, wind_sat;

    logic                         out_valid_reg, out_valid_next;
    logic [ID_W-1:0]              out_id_reg;
    logic signed [WIND_OUT_W-1:0] out_wind_reg;
    logic                         out_inside_reg, out_drop_reg;

    assign in_x = signed'(items.coord_x[COORD_BITS-1:0]);
    assign in_y = signed'(items.coord_y[COORD_BITS-1:0]);

    assign accept   = items.valid && items_ready;
    assign is_load  = accept && (items.mode == MODE_LOAD);
    assign is_query = accept && (items.mode == MODE_QUERY);

    assign base_count = items.new_polygon ? '0 : count_reg;
    assign wr_en      = is_load && (base_count < CNT_MAX);
    assign last_idx   = AW'(count_reg - CNT_W'(1));
    assign out_free   = !out_valid_reg || results.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                    state_next = (count_reg == '0) ? ST_DONE : ST_WALK;
            end
            ST_WALK:
            begin
                if (idx_reg == last_idx)
                    state_next = ST_WRAP;
            end
            ST_WRAP:  state_next = ST_DRAIN;
            ST_DRAIN:
            begin
                if (done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        items_ready = 1'b0;
        clear       = 1'b0;
        load_out    = 1'b0;
        tag         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                items_ready = 1'b1;
                clear       = is_query;
            end
            ST_WALK:
            begin
                tag.valid = 1'b1;
                tag.first = (idx_reg == '0);
            end
            ST_WRAP:
            begin
                tag.valid = 1'b1;
                tag.wrap  = 1'b1;
            end
            ST_DONE:  load_out = out_free;
            default:  items_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (is_load)
        begin
            ovf_next = (items.new_polygon ? 1'b0 : ovf_reg) || (base_count == CNT_MAX);
            if (base_count < CNT_MAX)
                count_next = base_count + CNT_W'(1);
            else
                count_next = base_count;
        end
    end

    always_comb
    begin
        idx_next = '0;
        if (state_reg == ST_WALK)
            idx_next = idx_reg + AW'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
            id_reg <= items.point_id;
        end
        if (load_out)
        begin
            out_id_reg     <= id_reg;
            out_wind_reg   <= wind_sat[WIND_OUT_W-1:0];
            out_inside_reg <= (acc != '0);
            out_drop_reg   <= ovf_reg;
        end
    end

    assign acc_ext  = SAT_W'(acc);
    assign wind_sat = (acc_ext > W_MAX) ? W_MAX :
                      (acc_ext < W_MIN) ? W_MIN : acc_ext;

    wnpip_vstore #(
        .DEPTH (MAX_VERTICES),
        .CW    (COORD_BITS),
        .AW    (AW)
    ) u_vstore (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (base_count[AW-1:0]),
        .wr_x    (in_x),
        .wr_y    (in_y),
        .rd_en   (tag.valid),
        .rd_addr (idx_reg),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    wnpip_edge #(
        .CW     (COORD_BITS),
        .WIND_W (WIND_W)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clear),
        .tag   (tag),
        .rd_x  (rd_x),
        .rd_y  (rd_y),
        .px    (px_reg),
        .py    (py_reg),
        .acc   (acc),
        .done  (done)
    );

    assign items.ready              = items_ready;
    assign results.valid            = out_valid_reg;
    assign results.result_id        = out_id_reg;
    assign results.winding          = out_wind_reg;
    assign results.inside_res       = out_inside_reg;
    assign results.vertices_dropped = out_drop_reg;

endmodule

// ===== rtl/wnpip_vstore.sv =====
// Vertex store: x and y memories, one write port, one registered read port.
// Depends on wnpip_pkg.
module wnpip_vstore #(
    parameter int DEPTH = wnpip_pkg::MAX_VERTICES_DEF,
    parameter int CW    = wnpip_pkg::COORD_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [CW-1:0] wr_x,
    input  logic signed [CW-1:0] wr_y,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic signed [CW-1:0] rd_x,
    output logic signed [CW-1:0] rd_y
);
    import wnpip_pkg::*;

    logic [CW-1:0] mem_x [DEPTH];
    logic [CW-1:0] mem_y [DEPTH];
    logic [CW-1:0] rd_x_reg;
    logic [CW-1:0] rd_y_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    assign rd_x = signed'(rd_x_reg);
    assign rd_y = signed'(rd_y_reg);

endmodule

// ===== rtl/wnpip_edge.sv =====
// Edge evaluator: pairs consecutive vertices from the store, tests the crossing,
// forms the two cross-product terms, compares them and accumulates the winding.
// Depends on wnpip_pkg.
module wnpip_edge #(
    parameter int CW     = wnpip_pkg::COORD_BITS_DEF,
    parameter int WIND_W = wnpip_pkg::WIND_OUT_W + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  wnpip_pkg::rd_tag_t       tag,
    input  logic signed [CW-1:0]     rd_x,
    input  logic signed [CW-1:0]     rd_y,
    input  logic signed [CW-1:0]     px,
    input  logic signed [CW-1:0]     py,
    output logic signed [WIND_W-1:0] acc,
    output logic                     done
);
    import wnpip_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    rd_tag_t t_reg;

    logic signed [CW-1:0] first_x_reg, first_y_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    logic signed [CW-1:0] cur_x, cur_y;
    logic                 e_valid;

    logic                 s1_valid_reg, s1_wrap_reg, s1_up_reg, s1_dn_reg;
    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg;

    logic                 s2_valid_reg, s2_wrap_reg, s2_up_reg, s2_dn_reg;
    logic signed [PW-1:0] p_reg, q_reg;

    logic signed [WIND_W-1:0] acc_reg, acc_next;
    logic                     done_reg, done_next;

    // wrap edge closes back onto vertex 0
    assign cur_x   = t_reg.wrap ? first_x_reg : rd_x;
    assign cur_y   = t_reg.wrap ? first_y_reg : rd_y;
    assign e_valid = t_reg.valid && !t_reg.first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            t_reg        <= tag;
            s1_valid_reg <= e_valid;
            s2_valid_reg <= s1_valid_reg;
            acc_reg      <= acc_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_reg.valid && !t_reg.wrap)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            if (t_reg.first)
            begin
                first_x_reg <= rd_x;
                first_y_reg <= rd_y;
            end
        end
        s1_wrap_reg <= t_reg.wrap;
        s1_up_reg   <= (prev_y_reg <= py) && (cur_y > py);
        s1_dn_reg   <= (prev_y_reg > py) && (cur_y <= py);
        a_reg       <= DW'(cur_x) - DW'(prev_x_reg);
        b_reg       <= DW'(py) - DW'(prev_y_reg);
        c_reg       <= DW'(px) - DW'(prev_x_reg);
        d_reg       <= DW'(cur_y) - DW'(prev_y_reg);

        s2_wrap_reg <= s1_wrap_reg;
        s2_up_reg   <= s1_up_reg;
        s2_dn_reg   <= s1_dn_reg;
        p_reg       <= PW'(a_reg) * PW'(b_reg);
        q_reg       <= PW'(c_reg) * PW'(d_reg);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        done_next = done_reg;
        if (clear)
        begin
            acc_next  = '0;
            done_next = 1'b0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_up_reg && (p_reg > q_reg))
                acc_next = acc_reg + WIND_W'(1);
            else if (s2_dn_reg && (p_reg < q_reg))
                acc_next = acc_reg - WIND_W'(1);
            if (s2_wrap_reg)
                done_next = 1'b1;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== test/winding_number_point_in_polygon_tb.sv =====
// Self-checking testbench for winding_number_point_in_polygon: a directed table,
// then random polygons and point queries, checked against an in-bench predictor.
// Depends on wnpip_pkg, wnpip_if and the RTL of the block.
module winding_number_point_in_polygon_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wnpip_pkg::*;

    localparam int MAX_VERTS    = MAX_VERTICES_DEF;
    localparam int N_DIRECTED   = 22;
    localparam int RANDOM_WORDS = 580;
    localparam int STALL_LIMIT  = 6000;
    localparam int SHOWN_ERRORS = 10;

    localparam logic signed [FIELD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] C_MAX = 32'sh7FFF_FFFF;

    localparam int SQUARE_X [4] = '{-1, 1, 1, -1};
    localparam int SQUARE_Y [4] = '{-1, -1, 1, 1};

    typedef struct {
        logic                         mode;
        logic                         new_polygon;
        logic signed [FIELD_W-1:0]    x;
        logic signed [FIELD_W-1:0]    y;
        logic [ID_W-1:0]              id;
        logic                         typed;
        logic signed [WIND_OUT_W-1:0] wind;
        logic                         in_poly;
        logic                         dropped;
    } word_t;

    typedef struct {
        logic [ID_W-1:0]              id;
        logic signed [WIND_OUT_W-1:0] wind;
        logic                         in_poly;
        logic                         dropped;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    wnpip_item_if items ();
    wnpip_res_if  results ();

    winding_number_point_in_polygon #(
        .MAX_VERTICES (MAX_VERTS),
        .COORD_BITS   (COORD_BITS_DEF)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    always #5 clk = ~clk;

    // predictor state
    logic signed [FIELD_W-1:0] corner_x [MAX_VERTS];
    logic signed [FIELD_W-1:0] corner_y [MAX_VERTS];
    int      corner_count = 0;
    logic    corner_lost  = 1'b0;
    answer_t answers_due [$];
    answer_t got;

    int   words_sent = 0;
    int   mismatches = 0;
    int   stalled    = 0;
    logic calm;

    assign calm = (words_sent >= N_DIRECTED + 150) && (words_sent < N_DIRECTED + 270);

    // typed rows hold results that follow at a glance from the geometry
    word_t directed_rows [N_DIRECTED] = '{
        '{MODE_QUERY, 1'b0, 0, 0, 32'hFFFF_FFFF, 1'b1, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b1, C_MIN, C_MIN, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b0, C_MAX, C_MIN, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b0, C_MAX, C_MAX, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b0, C_MIN, C_MAX, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_QUERY, 1'b0, 0, 0, 32'd1, 1'b1, 1, 1'b1, 1'b0},
        '{MODE_QUERY, 1'b0, C_MAX, 0, 32'd2, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_QUERY, 1'b0, C_MIN, C_MIN, 32'd0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_QUERY, 1'b1, -1, -1, 32'd3, 1'b1, 1, 1'b1, 1'b0},
        '{MODE_QUERY, 1'b0, C_MAX - 1, C_MIN, 32'd4, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b1, 0, 0, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b0, 0, 100, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b0, 100, 0, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_QUERY, 1'b0, 10, 10, 32'd5, 1'b1, -1, 1'b1, 1'b0},
        '{MODE_LOAD,  1'b0, 0, 0, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_QUERY, 1'b0, 10, 10, 32'd6, 1'b1, -1, 1'b1, 1'b0},
        '{MODE_QUERY, 1'b0, 0, 50, 32'd7, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b1, 5, 5, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_QUERY, 1'b0, 5, 5, 32'd8, 1'b1, 0, 1'b0, 1'b0},
        '{MODE_LOAD,  1'b0, 5, -5, 32'h0, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_QUERY, 1'b0, 0, 0, 32'd9, 1'b0, 0, 1'b0, 1'b0},
        '{MODE_QUERY, 1'b0, C_MIN, C_MAX, 32'h8000_0000, 1'b0, 0, 1'b0, 1'b0}
    };

    // sign of the exact cross product: >0 point left of the edge, <0 right
    function automatic int edge_side(input logic signed [FIELD_W-1:0] x0, y0, x1, y1, px, py);
        logic signed [FIELD_W+1:0]   ex, ey, qx, qy;
        logic signed [2*FIELD_W+3:0] lhs, rhs;
        ex  = x1 - x0;
        ey  = y1 - y0;
        qx  = px - x0;
        qy  = py - y0;
        lhs = ex * qy;
        rhs = qx * ey;
        return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
    endfunction

    function automatic int polygon_winding(input logic signed [FIELD_W-1:0] px, py);
        int w;
        int j;
        w = 0;
        for (int i = 0; i < corner_count; i++)
        begin
            j = (i + 1 < corner_count) ? i + 1 : 0;
            if (corner_y[i] <= py)
            begin
                if (corner_y[j] > py &&
                    edge_side(corner_x[i], corner_y[i], corner_x[j], corner_y[j], px, py) > 0)
                    w++;
            end
            else if (corner_y[j] <= py &&
                     edge_side(corner_x[i], corner_y[i], corner_x[j], corner_y[j], px, py) < 0)
                w--;
        end
        if (w > 1023)
            w = 1023;
        if (w < -1024)
            w = -1024;
        return w;
    endfunction

    task automatic absorb_word(input word_t w);
        answer_t a;
        int      wn;
        words_sent++;
        if (w.mode == MODE_LOAD)
        begin
            if (w.new_polygon)
            begin
                corner_count = 0;
                corner_lost  = 1'b0;
            end
            if (corner_count < MAX_VERTS)
            begin
                corner_x[corner_count] = w.x;
                corner_y[corner_count] = w.y;
                corner_count++;
            end
            else
                corner_lost = 1'b1;
        end
        else
        begin
            a.id = w.id;
            if (w.typed)
            begin
                a.wind    = w.wind;
                a.in_poly = w.in_poly;
                a.dropped = w.dropped;
            end
            else
            begin
                wn        = polygon_winding(w.x, w.y);
                a.wind    = WIND_OUT_W'(wn);
                a.in_poly = (wn != 0);
                a.dropped = corner_lost;
            end
            answers_due = {answers_due, a};
        end
    endtask

    // called and returns at a falling edge
    task automatic send_word(input word_t w);
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            items.valid <= 1'b0;
            @(negedge clk);
        end
        items.valid       <= 1'b1;
        items.mode        <= w.mode;
        items.new_polygon <= w.new_polygon;
        items.coord_x     <= w.x;
        items.coord_y     <= w.y;
        items.point_id    <= w.id;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        absorb_word(w);
        @(negedge clk);
    endtask

    function automatic word_t make_word(input logic mode, input logic fresh,
                                        input logic signed [FIELD_W-1:0] x, y);
        word_t w;
        w.mode        = mode;
        w.new_polygon = fresh;
        w.x           = x;
        w.y           = y;
        w.id          = $urandom;
        w.typed       = 1'b0;
        w.wind        = '0;
        w.in_poly     = 1'b0;
        w.dropped     = 1'b0;
        return w;
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_coord(input int shift);
        return $signed($urandom) >>> shift;
    endfunction

    function automatic logic signed [FIELD_W-1:0] grid_coord();
        return $signed(32'($urandom_range(0, 6))) - 3;
    endfunction

    task automatic run_random();
        logic signed [FIELD_W-1:0] vx [$];
        logic signed [FIELD_W-1:0] vy [$];
        logic signed [FIELD_W-1:0] px, py;
        int     plain_words;
        int     kind, shift, n, turns, pick, e, c;
        logic   ccw;
        longint mx, my, half, sx, sy;
        plain_words = 0;
        while (plain_words < RANDOM_WORDS)
        begin
            vx.delete();
            vy.delete();
            kind  = $urandom_range(0, 99);
            shift = 12 * $urandom_range(0, 2);
            if (kind < 45)
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                begin
                    vx = {vx, rand_coord(shift)};
                    vy = {vy, rand_coord(shift)};
                end
            end
            else if (kind < 75)
            begin
                turns = $urandom_range(1, 3);
                ccw   = 1'($urandom_range(0, 1));
                mx    = rand_coord(shift + 1);
                my    = rand_coord(shift + 1);
                half  = $urandom_range(1, 1 << (30 - shift));
                for (int i = 0; i < 4 * turns; i++)
                begin
                    c  = ccw ? i % 4 : 3 - i % 4;
                    vx = {vx, FIELD_W'(mx + half * SQUARE_X[c])};
                    vy = {vy, FIELD_W'(my + half * SQUARE_Y[c])};
                end
                if ($urandom_range(0, 9) < 3)
                begin
                    vx = {vx, vx[0]};
                    vy = {vy, vy[0]};
                end
            end
            else
            begin
                n = $urandom_range(3, 8);
                for (int i = 0; i < n; i++)
                begin
                    vx = {vx, grid_coord()};
                    vy = {vy, grid_coord()};
                end
            end

            if ($urandom_range(0, 99) < 8)
            begin
                send_word(make_word(MODE_QUERY, 1'($urandom_range(0, 1)), rand_coord(shift),
                                    rand_coord(shift)));
                plain_words++;
            end
            for (int i = 0; i < vx.size(); i++)
                send_word(make_word(MODE_LOAD, i == 0 && $urandom_range(0, 9) != 0, vx[i], vy[i]));
            plain_words += vx.size();

            sx = 0;
            sy = 0;
            foreach (vx[i])
            begin
                sx += vx[i];
                sy += vy[i];
            end
            n = $urandom_range(1, 5);
            for (int q = 0; q < n; q++)
            begin
                pick = $urandom_range(0, 9);
                e    = $urandom_range(0, vx.size() - 1);
                if (pick < 4)
                begin
                    px = FIELD_W'(sx / vx.size());
                    py = FIELD_W'(sy / vy.size());
                end
                else if (pick < 6)
                begin
                    px = vx[e];
                    py = vy[e];
                end
                else if (pick < 7)
                begin
                    c  = (e + 1) % vx.size();
                    px = FIELD_W'((longint'(vx[e]) + vx[c]) >>> 1);
                    py = FIELD_W'((longint'(vy[e]) + vy[c]) >>> 1);
                end
                else if (kind >= 75)
                begin
                    px = grid_coord();
                    py = grid_coord();
                end
                else
                begin
                    px = rand_coord(shift);
                    py = rand_coord(shift);
                end
                send_word(make_word(MODE_QUERY, 1'($urandom_range(0, 1)), px, py));
            end
            plain_words += n;
        end
    endtask

    always @(negedge clk)
        results.ready <= calm || $urandom_range(0, 99) >= 14;

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result word: id=%h winding=%0d",
                             results.result_id, results.winding);
            end
            else
            begin
                got = answers_due.pop_front();
                if (results.result_id !== got.id || results.winding !== got.wind ||
                    results.inside_res !== got.in_poly ||
                    results.vertices_dropped !== got.dropped)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("expected id=%h w=%0d in=%b drop=%b, got id=%h w=%0d in=%b drop=%b",
                                 got.id, got.wind, got.in_poly, got.dropped,
                                 results.result_id, results.winding, results.inside_res,
                                 results.vertices_dropped);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
            stalled = 0;
        else
            stalled++;
        if (stalled >= STALL_LIMIT)
        begin
            $display("winding_number_point_in_polygon: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        items.valid       = 1'b0;
        items.mode        = MODE_LOAD;
        items.new_polygon = 1'b0;
        items.coord_x     = '0;
        items.coord_y     = '0;
        items.point_id    = '0;
        results.ready     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i]);
        run_random();
        items.valid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (MAX_VERTS + 16) @(posedge clk);

        if (mismatches == 0 && answers_due.size() == 0)
            $display("winding_number_point_in_polygon: match");
        else
            $display("winding_number_point_in_polygon: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wnpip_pkg.sv
rtl/wnpip_if.sv
rtl/wnpip_vstore.sv
rtl/wnpip_edge.sv
rtl/winding_number_point_in_polygon.sv
test/winding_number_point_in_polygon_tb.sv
